[sv/bagav_pkg.sv]
// Shared types, constants and gate tables for the band amplitude gated averager.
package bagav_pkg;

   localparam int BANDS       = 7;
   localparam int MAX_SWEEPS  = 9;
   localparam int SAMPLE_W    = 10;
   localparam int SUM_W       = 14;
   localparam int BAND_W      = 3;
   localparam int COUNT_W     = 4;
   localparam int BIT_W       = $clog2(SUM_W);
   localparam logic [COUNT_W-1:0] SWEEP_RESET = COUNT_W'(MAX_SWEEPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIVIDE,
      ST_PUT,
      ST_WAIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic load;
      logic step;
      logic put;
      logic advance;
   } ctrl_type;

   typedef struct packed {
      logic set_done;
      logic div_done;
      logic last_band;
      logic rsp_taken;
   } stat_type;

   function automatic logic [SAMPLE_W-1:0] read_gate(input logic [BAND_W-1:0] band);
      logic [SAMPLE_W-1:0] gate;
      unique case (band)
         3'd0:    gate = 10'd125;
         3'd1:    gate = 10'd150;
         3'd2:    gate = 10'd150;
         3'd3:    gate = 10'd160;
         3'd4:    gate = 10'd225;
         3'd5:    gate = 10'd360;
         default: gate = 10'd1023;
      endcase
      return gate;
   endfunction

   function automatic logic [SAMPLE_W-1:0] final_gate(input logic [BAND_W-1:0] band);
      logic [SAMPLE_W-1:0] gate;
      unique case (band)
         3'd0:    gate = 10'd160;
         3'd1:    gate = 10'd100;
         3'd2:    gate = 10'd120;
         3'd3:    gate = 10'd120;
         3'd4:    gate = 10'd160;
         3'd5:    gate = 10'd200;
         default: gate = 10'd1023;
      endcase
      return gate;
   endfunction

endpackage

[sv/band_amplitude_gated_averager.sv]
// Top level of the band amplitude gated averager: controller and datapath.
//
// Samples arrive on the req_ channel, seven per sweep, band 0 first. A sample
// word is accepted when req_valid is high and req_stall is low; one sample can
// be taken every cycle while the block is collecting. A sample below its band's
// read cutoff adds nothing to that band's accumulator.
// csr_write_data sets the sweeps per set (0 acts as 1, above 9 acts as 9);
// write it only while the block is idle.
// After the last sample of the last sweep, req_stall rises and the seven
// averaged words leave on the rsp_ channel in band order, rsp_last on band 6.
// Each word needs a load step, the one-bit-per-cycle divider and a put step
// that registers the result; the divide for a further word starts only after
// the previous word is taken.
// While rsp_stall is high the result word holds and the divider waits.
// Reset clears the accumulators and counters and sets the count to 9.
module band_amplitude_gated_averager
   import bagav_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [COUNT_W-1:0]  csr_write_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [SAMPLE_W-1:0] req_sample,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [BAND_W-1:0]   rsp_band,
   output logic [SAMPLE_W-1:0] rsp_amplitude,
   output logic                rsp_last
);

   ctrl_type ctrl;
   stat_type stat;

   bagav_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .ctrl      (ctrl),
      .req_stall (req_stall)
   );

   bagav_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .stat             (stat),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_band         (rsp_band),
      .rsp_amplitude    (rsp_amplitude),
      .rsp_last         (rsp_last)
   );

   a_no_intake_during_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("sample intake open while a result word is pending");

   a_last_marks_band6: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_band == BAND_W'(BANDS - 1))))
      else $error("last flag does not match final band");

   a_resume_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last) |=> !req_stall && !rsp_valid)
      else $error("intake not resumed after final word");

endmodule

[sv/bagav_ctrl.sv]
// Controller state machine: sample intake, per-band divide and result hand-off.
module bagav_ctrl
   import bagav_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  stat_type stat,
   output ctrl_type ctrl,
   output logic     req_stall
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && stat.set_done) state_in = ST_LOAD;
         end
         ST_LOAD:   state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (stat.div_done) state_in = ST_PUT;
         end
         ST_PUT:    state_in = ST_WAIT;
         ST_WAIT: begin
            if (stat.rsp_taken) state_in = stat.last_band ? ST_IDLE : ST_LOAD;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl      = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            ctrl.accept = req_valid;
         end
         ST_LOAD:   ctrl.load = 1'b1;
         ST_DIVIDE: ctrl.step = 1'b1;
         ST_PUT:    ctrl.put  = 1'b1;
         ST_WAIT:   ctrl.advance = stat.rsp_taken;
         default:   ctrl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

[sv/bagav_datapath.sv]
// Datapath: band accumulators, sweep counters, serial divider and result register.
module bagav_datapath
   import bagav_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ctrl_type            ctrl,
   output stat_type            stat,
   input  logic                csr_write_enable,
   input  logic [COUNT_W-1:0]  csr_write_data,
   input  logic [SAMPLE_W-1:0] req_sample,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [BAND_W-1:0]   rsp_band,
   output logic [SAMPLE_W-1:0] rsp_amplitude,
   output logic                rsp_last
);

   logic [SUM_W-1:0]    band_sum_ff [BANDS];
   logic [SUM_W-1:0]    band_sum_in [BANDS];
   logic [BAND_W-1:0]   band_pos_ff, band_pos_in;
   logic [COUNT_W-1:0]  sweep_pos_ff, sweep_pos_in;
   logic [COUNT_W-1:0]  sweep_count_ff, sweep_count_in;
   logic [COUNT_W-1:0]  divisor_ff, divisor_in;
   logic [COUNT_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]    quo_ff, quo_in;
   logic [BIT_W-1:0]    bit_ff, bit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BAND_W-1:0]   rsp_band_ff, rsp_band_in;
   logic [SAMPLE_W-1:0] rsp_amp_ff, rsp_amp_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [COUNT_W-1:0]  eff_count;
   logic [COUNT_W-1:0]  sweep_next;
   logic [SUM_W-1:0]    sum_sel;
   logic [COUNT_W:0]    rem_shift;
   logic                qbit;
   logic                last_band;

   always_comb begin
      eff_count = sweep_count_ff;
      if (sweep_count_ff == '0) eff_count = COUNT_W'(1);
      else if (sweep_count_ff > COUNT_W'(MAX_SWEEPS)) eff_count = COUNT_W'(MAX_SWEEPS);
   end

   assign sweep_next = sweep_pos_ff + COUNT_W'(1);
   assign last_band  = (band_pos_ff == BAND_W'(BANDS - 1));
   assign sum_sel    = band_sum_ff[band_pos_ff];
   assign rem_shift  = {rem_ff, quo_ff[SUM_W-1]};
   assign qbit       = (rem_shift >= {1'b0, divisor_ff});

   assign stat.set_done  = last_band && (sweep_next >= eff_count);
   assign stat.div_done  = (bit_ff == '0);
   assign stat.last_band = last_band;
   assign stat.rsp_taken = rsp_valid_ff && !rsp_stall;

   always_comb begin
      band_sum_in    = band_sum_ff;
      band_pos_in    = band_pos_ff;
      sweep_pos_in   = sweep_pos_ff;
      sweep_count_in = sweep_count_ff;
      divisor_in     = divisor_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      bit_in         = bit_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_band_in    = rsp_band_ff;
      rsp_amp_in     = rsp_amp_ff;
      rsp_last_in    = rsp_last_ff;

      if (csr_write_enable) sweep_count_in = csr_write_data;

      if (ctrl.accept) begin
         if (req_sample >= read_gate(band_pos_ff)) begin
            band_sum_in[band_pos_ff] = sum_sel + SUM_W'(req_sample);
         end
         band_pos_in = last_band ? '0 : band_pos_ff + BAND_W'(1);
         if (stat.set_done)  sweep_pos_in = '0;
         else if (last_band) sweep_pos_in = sweep_next;
      end

      if (ctrl.load) begin
         quo_in                   = sum_sel;
         band_sum_in[band_pos_ff] = '0;
         rem_in                   = '0;
         bit_in                   = BIT_W'(SUM_W - 1);
         divisor_in               = eff_count;
      end

      if (ctrl.step) begin
         rem_in = qbit ? COUNT_W'(rem_shift - {1'b0, divisor_ff}) : rem_shift[COUNT_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], qbit};
         bit_in = bit_ff - BIT_W'(1);
      end

      if (ctrl.put) begin
         rsp_valid_in = 1'b1;
         rsp_band_in  = band_pos_ff;
         rsp_last_in  = last_band;
         rsp_amp_in   = (quo_ff < SUM_W'(final_gate(band_pos_ff))) ? '0
                                                                  : quo_ff[SAMPLE_W-1:0];
      end

      if (stat.rsp_taken) rsp_valid_in = 1'b0;

      if (ctrl.advance) band_pos_in = last_band ? '0 : band_pos_ff + BAND_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BANDS; i++) band_sum_ff[i] <= '0;
         band_pos_ff    <= '0;
         sweep_pos_ff   <= '0;
         sweep_count_ff <= SWEEP_RESET;
         rsp_valid_ff   <= 1'b0;
         bit_ff         <= '0;
      end else begin
         band_sum_ff    <= band_sum_in;
         band_pos_ff    <= band_pos_in;
         sweep_pos_ff   <= sweep_pos_in;
         sweep_count_ff <= sweep_count_in;
         rsp_valid_ff   <= rsp_valid_in;
         bit_ff         <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      rsp_band_ff <= rsp_band_in;
      rsp_amp_ff  <= rsp_amp_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_band      = rsp_band_ff;
   assign rsp_amplitude = rsp_amp_ff;
   assign rsp_last      = rsp_last_ff;

   // remainder of the serial divide stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      ctrl.step |=> rem_ff < divisor_ff)
      else $error("divider remainder not below divisor");

   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      sweep_pos_ff < COUNT_W'(MAX_SWEEPS))
      else $error("sweep position out of range");

endmodule

[tb/sv/tb_band_amplitude_gated_averager.sv]
// Self-checking testbench for the band amplitude gated averager, with its averaging scoreboard.
`timescale 1ns / 1ps

import bagav_pkg::*;

typedef struct packed {
   logic [BAND_W-1:0]   band;
   logic [SAMPLE_W-1:0] amplitude;
   logic                last;
} band_word_type;

typedef enum int {
   SW_RANDOM,
   SW_NEAR,
   SW_BELOW,
   SW_AT,
   SW_MAX,
   SW_ZERO
} sweep_mode_type;

class band_average_board;
   logic [SAMPLE_W-1:0] pass_floor [BANDS];
   logic [SAMPLE_W-1:0] keep_floor [BANDS];
   logic [COUNT_W-1:0]  sweeps_set;
   logic [BAND_W-1:0]   next_band;
   logic [COUNT_W-1:0]  sweeps_done;
   logic [SUM_W-1:0]    band_total [BANDS];
   band_word_type       due_words [$];
   int                  errors;

   function new();
      pass_floor = '{10'd125, 10'd150, 10'd150, 10'd160, 10'd225, 10'd360, 10'd1023};
      keep_floor = '{10'd160, 10'd100, 10'd120, 10'd120, 10'd160, 10'd200, 10'd1023};
      sweeps_set = COUNT_W'(MAX_SWEEPS);
      next_band = '0;
      sweeps_done = '0;
      for (int k = 0; k < BANDS; k++) band_total[k] = '0;
      errors = 0;
   endfunction

   function void set_sweeps(input logic [COUNT_W-1:0] value);
      sweeps_set = value;
   endfunction

   function logic [COUNT_W-1:0] divisor();
      if (sweeps_set == '0) return COUNT_W'(1);
      if (sweeps_set > COUNT_W'(MAX_SWEEPS)) return COUNT_W'(MAX_SWEEPS);
      return sweeps_set;
   endfunction

   function int pending();
      return due_words.size();
   endfunction

   function void note_sample(input logic [SAMPLE_W-1:0] sample);
      logic [COUNT_W-1:0] div;
      logic [SUM_W-1:0]   avg;
      band_word_type      w;
      if (sample >= pass_floor[next_band])
         band_total[next_band] = band_total[next_band] + SUM_W'(sample);
      if (next_band != BAND_W'(BANDS - 1)) begin
         next_band = next_band + BAND_W'(1);
         return;
      end
      next_band = '0;
      sweeps_done = sweeps_done + COUNT_W'(1);
      div = divisor();
      if (sweeps_done < div) return;
      for (int k = 0; k < BANDS; k++) begin
         avg = band_total[k] / SUM_W'(div);
         if (avg < SUM_W'(keep_floor[k])) avg = '0;
         w.band = BAND_W'(k);
         w.amplitude = avg[SAMPLE_W-1:0];
         w.last = (k == BANDS - 1);
         due_words.push_back(w);
         band_total[k] = '0;
      end
      sweeps_done = '0;
   endfunction

   task report(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
   endtask

   task check_word(input logic [BAND_W-1:0] band, input logic [SAMPLE_W-1:0] amplitude,
                   input logic last);
      band_word_type w;
      if (due_words.size() == 0) begin
         report($sformatf("unexpected word band %0d amplitude %0d last %0b",
                          band, amplitude, last));
         return;
      end
      w = due_words.pop_front();
      if (band !== w.band)
         report($sformatf("band %0d, want %0d", band, w.band));
      if (amplitude !== w.amplitude)
         report($sformatf("band %0d amplitude %0d, want %0d", w.band, amplitude, w.amplitude));
      if (last !== w.last)
         report($sformatf("band %0d last %0b, want %0b", w.band, last, w.last));
   endtask
endclass

module tb_band_amplitude_gated_averager;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 40;
   localparam int RANDOM_ITEMS = 350;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [COUNT_W-1:0]  csr_write_data = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [BAND_W-1:0]   rsp_band;
   logic [SAMPLE_W-1:0] rsp_amplitude;
   logic                rsp_last;

   band_average_board board = new();
   bit quick = 1'b0;
   int sent = 0;
   int cycles = 0;

   band_amplitude_gated_averager DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_band         (rsp_band),
      .rsp_amplitude    (rsp_amplitude),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[band_amplitude_gated_averager] ERROR");
         $finish;
      end
   end

   function automatic logic [SAMPLE_W-1:0] pick_sample(input sweep_mode_type mode, input int b);
      int v;
      unique case (mode)
         SW_BELOW: v = int'(board.pass_floor[b]) - 1;
         SW_AT:    v = int'(board.pass_floor[b]);
         SW_MAX:   v = 1023;
         SW_ZERO:  v = 0;
         SW_NEAR: begin
            v = ($urandom_range(0, 1) == 1) ? int'(board.pass_floor[b])
                                            : int'(board.keep_floor[b]);
            v = v + int'($urandom_range(0, 6)) - 3;
            if (v > 1023) v = 1023;
         end
         default:  v = int'($urandom_range(0, 1023));
      endcase
      return SAMPLE_W'(v);
   endfunction

   task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
      int gap;
      gap = quick ? 0 : int'($urandom_range(0, 16));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= sample;
      @(posedge clock);
      // hold the word until the block takes it
      while (req_stall) @(posedge clock);
      board.note_sample(sample);
      sent++;
   endtask

   task automatic send_sweep(input sweep_mode_type mode);
      for (int b = 0; b < BANDS; b++) send_sample(pick_sample(mode, b));
   endtask

   task automatic write_sweeps(input logic [COUNT_W-1:0] value);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.set_sweeps(value);
   endtask

   initial begin : drain
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_valid && !rsp_stall) begin
               board.check_word(rsp_band, rsp_amplitude, rsp_last);
               hold = quick ? 0 : int'($urandom_range(0, 16));
               rsp_stall <= (hold > 0);
            end else if (hold > 0) begin
               hold--;
               rsp_stall <= (hold > 0);
            end
         end
      end
   end

   initial begin : stimulus
      logic [COUNT_W-1:0] cnt;
      logic [COUNT_W-1:0] first_counts [3];
      int phase;
      int r;
      int remaining;
      int nsweeps;
      int goal;
      sweep_mode_type mode;

      first_counts = '{4'd15, 4'd9, 4'd2};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // zero count acts as one; read cutoffs just missed, then just met
      write_sweeps(4'd0);
      send_sweep(SW_BELOW);
      send_sweep(SW_AT);
      // lower the count to the number of sweeps already taken
      write_sweeps(4'd3);
      send_sweep(SW_MAX);
      write_sweeps(4'd1);
      send_sweep(SW_ZERO);

      goal = sent + RANDOM_ITEMS;
      phase = 0;
      while (sent < goal) begin
         if (phase < 3) begin
            cnt = first_counts[phase];
         end else begin
            r = $urandom_range(0, 9);
            unique case (r)
               0:       cnt = 4'd0;
               1:       cnt = 4'd15;
               2, 3, 4: cnt = 4'd1;
               5, 6:    cnt = 4'd2;
               7:       cnt = 4'd3;
               8:       cnt = COUNT_W'($urandom_range(4, 9));
               default: cnt = COUNT_W'($urandom_range(10, 15));
            endcase
         end
         write_sweeps(cnt);
         quick = ($urandom_range(0, 4) == 0);
         remaining = int'(board.divisor()) - int'(board.sweeps_done);
         if (remaining < 1) remaining = 1;
         nsweeps = (phase >= 3 && $urandom_range(0, 3) == 0) ?
                   int'($urandom_range(1, remaining)) : remaining;
         for (int s = 0; s < nsweeps; s++) begin
            r = $urandom_range(0, 9);
            mode = (r < 4) ? SW_RANDOM : (r < 8) ? SW_NEAR :
                   (r == 8) ? SW_MAX : SW_ZERO;
            send_sweep(mode);
         end
         // break the band alignment now and then
         if ($urandom_range(0, 7) == 0) begin
            r = $urandom_range(1, BANDS - 1);
            for (int k = 0; k < r; k++) send_sample(SAMPLE_W'($urandom_range(0, 1023)));
         end
         phase++;
      end

      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("[band_amplitude_gated_averager] OK");
      end else begin
         $display("[band_amplitude_gated_averager] ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/bagav_pkg.sv
sv/bagav_ctrl.sv
sv/bagav_datapath.sv
sv/band_amplitude_gated_averager.sv
tb/sv/tb_band_amplitude_gated_averager.sv
